[hdl/biou_pkg.sv]
`timescale 1ns / 1ps

package biou_pkg;

  // Width of every input coordinate and size field.
  localparam int COORD_WIDTH = 16;

  // A doubled edge (2*center -/+ size) and the difference of two such edges.
  localparam int EDGE_W = COORD_WIDTH + 2;
  localparam int DIFF_W = COORD_WIDTH + 3;

  // A non-negative doubled overlap is at most twice the smaller size.
  localparam int OV_W = COORD_WIDTH + 1;

  // Four times an area, and the four-times intersection.
  localparam int PROD_W = 2 * COORD_WIDTH + 2;

  // Sum of two four-times areas.
  localparam int UNION_W = PROD_W + 1;

  // Result is unsigned Q1.15; the divider makes one quotient bit per stage.
  localparam int IOU_W = 16;
  localparam int DIV_STEPS = IOU_W;
  localparam int DIV_LAST = DIV_STEPS - 1;

  // Queue between the geometry front end and the divider.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [COORD_WIDTH-1:0] dim_t;

  // One division job handed from the front end to the divider.
  typedef struct packed {
    logic [UNION_W-1:0] inter;
    logic [UNION_W-1:0] uni;
    logic               empty;
  } biou_job_t;

  // Outcome of one restoring-division step.
  typedef struct packed {
    logic               ge;
    logic [UNION_W-1:0] rem;
  } biou_step_t;

endpackage

[hdl/biou_front.sv]
`timescale 1ns / 1ps

module biou_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  biou_pkg::coord_t    in_a_center_x,
  input  biou_pkg::coord_t    in_a_center_y,
  input  biou_pkg::dim_t      in_a_width,
  input  biou_pkg::dim_t      in_a_height,
  input  biou_pkg::coord_t    in_b_center_x,
  input  biou_pkg::coord_t    in_b_center_y,
  input  biou_pkg::dim_t      in_b_width,
  input  biou_pkg::dim_t      in_b_height,
  output logic                job_valid,
  input  logic                job_ready,
  output biou_pkg::biou_job_t job
);

  // Doubled overlap on one axis: smaller doubled right edge minus larger doubled left edge.
  function automatic logic signed [biou_pkg::DIFF_W-1:0] overlap2(
    input biou_pkg::coord_t c1,
    input biou_pkg::dim_t   s1,
    input biou_pkg::coord_t c2,
    input biou_pkg::dim_t   s2
  );
    logic signed [biou_pkg::EDGE_W-1:0] l1;
    logic signed [biou_pkg::EDGE_W-1:0] l2;
    logic signed [biou_pkg::EDGE_W-1:0] r1;
    logic signed [biou_pkg::EDGE_W-1:0] r2;
    logic signed [biou_pkg::EDGE_W-1:0] lft;
    logic signed [biou_pkg::EDGE_W-1:0] rgt;
    l1  = {c1[biou_pkg::COORD_WIDTH-1], c1, 1'b0} - {2'b00, s1};
    r1  = {c1[biou_pkg::COORD_WIDTH-1], c1, 1'b0} + {2'b00, s1};
    l2  = {c2[biou_pkg::COORD_WIDTH-1], c2, 1'b0} - {2'b00, s2};
    r2  = {c2[biou_pkg::COORD_WIDTH-1], c2, 1'b0} + {2'b00, s2};
    lft = (l1 > l2) ? l1 : l2;
    rgt = (r1 < r2) ? r1 : r2;
    return biou_pkg::DIFF_W'(rgt) - biou_pkg::DIFF_W'(lft);
  endfunction

  // Pipeline control: all three stages move together unless the last one is stuck.
  logic [2:0] vld_r;
  logic       adv;

  assign adv       = !vld_r[2] || job_ready;
  assign in_ready  = adv;
  assign job_valid = vld_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  // Stage A: overlaps on both axes and whether the boxes intersect at all.
  logic signed [biou_pkg::DIFF_W-1:0] ovx_d;
  logic signed [biou_pkg::DIFF_W-1:0] ovy_d;
  logic [biou_pkg::OV_W-1:0]          ovx_r;
  logic [biou_pkg::OV_W-1:0]          ovy_r;
  logic                               hit_r;
  biou_pkg::dim_t                     aw_r;
  biou_pkg::dim_t                     ah_r;
  biou_pkg::dim_t                     bw_r;
  biou_pkg::dim_t                     bh_r;

  always_comb begin
    ovx_d = overlap2(in_a_center_x, in_a_width, in_b_center_x, in_b_width);
    ovy_d = overlap2(in_a_center_y, in_a_height, in_b_center_y, in_b_height);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ovx_r <= ovx_d[biou_pkg::OV_W-1:0];
      ovy_r <= ovy_d[biou_pkg::OV_W-1:0];
      hit_r <= !ovx_d[biou_pkg::DIFF_W-1] && !ovy_d[biou_pkg::DIFF_W-1];
      aw_r  <= in_a_width;
      ah_r  <= in_a_height;
      bw_r  <= in_b_width;
      bh_r  <= in_b_height;
    end
  end

  // Stage B: the three products, each in its own multiplier.
  logic [biou_pkg::PROD_W-1:0]        inter_d;
  logic [2*biou_pkg::COORD_WIDTH-1:0] area_a_d;
  logic [2*biou_pkg::COORD_WIDTH-1:0] area_b_d;
  logic [biou_pkg::PROD_W-1:0]        inter_r;
  logic [biou_pkg::PROD_W-1:0]        area4_a_r;
  logic [biou_pkg::PROD_W-1:0]        area4_b_r;

  always_comb begin
    inter_d  = hit_r ? (biou_pkg::PROD_W'(ovx_r) * biou_pkg::PROD_W'(ovy_r)) : '0;
    area_a_d = (2*biou_pkg::COORD_WIDTH)'(aw_r) * (2*biou_pkg::COORD_WIDTH)'(ah_r);
    area_b_d = (2*biou_pkg::COORD_WIDTH)'(bw_r) * (2*biou_pkg::COORD_WIDTH)'(bh_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inter_r   <= inter_d;
      area4_a_r <= {area_a_d, 2'b00};
      area4_b_r <= {area_b_d, 2'b00};
    end
  end

  // Stage C: union of the two four-times areas, and the empty-union flag.
  logic [biou_pkg::UNION_W-1:0] uni_d;
  biou_pkg::biou_job_t          job_r;

  always_comb begin
    uni_d = biou_pkg::UNION_W'(area4_a_r) + biou_pkg::UNION_W'(area4_b_r)
          - biou_pkg::UNION_W'(inter_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      job_r.inter <= biou_pkg::UNION_W'(inter_r);
      job_r.uni   <= uni_d;
      job_r.empty <= (uni_d == '0);
    end
  end

  assign job = job_r;

endmodule

[hdl/biou_queue.sv]
`timescale 1ns / 1ps

module biou_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  biou_pkg::biou_job_t wr_job,
  output logic                rd_valid,
  input  logic                rd_ready,
  output biou_pkg::biou_job_t rd_job
);

  biou_pkg::biou_job_t               mem_r [biou_pkg::QUEUE_DEPTH];
  logic [biou_pkg::QUEUE_PTR_W-1:0]  wr_ptr_r;
  logic [biou_pkg::QUEUE_PTR_W-1:0]  rd_ptr_r;
  logic [biou_pkg::QUEUE_CNT_W-1:0]  cnt_r;
  logic                              do_wr;
  logic                              do_rd;

  assign wr_ready = (cnt_r != biou_pkg::QUEUE_CNT_W'(biou_pkg::QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_job   = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Next slot index, wrapping at the queue depth.
  function automatic logic [biou_pkg::QUEUE_PTR_W-1:0] ptr_inc(
    input logic [biou_pkg::QUEUE_PTR_W-1:0] p
  );
    if (p == biou_pkg::QUEUE_PTR_W'(biou_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_rd) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Storage slots.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

[hdl/biou_divider.sv]
`timescale 1ns / 1ps

module biou_divider (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   job_valid,
  output logic                   job_ready,
  input  biou_pkg::biou_job_t    job,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [biou_pkg::IOU_W-1:0] out_iou,
  output logic                   out_empty_union
);

  // One restoring step: subtract the divisor when the trial remainder reaches it.
  function automatic biou_pkg::biou_step_t div_step(
    input logic [biou_pkg::UNION_W:0]   trial,
    input logic [biou_pkg::UNION_W-1:0] d
  );
    biou_pkg::biou_step_t s;
    logic [biou_pkg::UNION_W:0] diff;
    diff  = trial - {1'b0, d};
    s.ge  = (trial >= {1'b0, d});
    s.rem = s.ge ? diff[biou_pkg::UNION_W-1:0] : trial[biou_pkg::UNION_W-1:0];
    return s;
  endfunction

  logic [biou_pkg::DIV_STEPS-1:0] vld_r;
  logic [biou_pkg::DIV_STEPS-1:0] emp_r;
  logic [biou_pkg::UNION_W-1:0]   uni_r [biou_pkg::DIV_STEPS];
  logic [biou_pkg::UNION_W-1:0]   rem_r [biou_pkg::DIV_STEPS];
  logic [biou_pkg::IOU_W-1:0]     quo_r [biou_pkg::DIV_STEPS];
  logic [biou_pkg::UNION_W-1:0]   rem_nxt [biou_pkg::DIV_STEPS];
  logic [biou_pkg::IOU_W-1:0]     quo_nxt [biou_pkg::DIV_STEPS];
  logic                           adv;

  // The whole pipeline holds while its last stage waits on the receiver.
  assign adv       = !vld_r[biou_pkg::DIV_LAST] || out_ready;
  assign job_ready = adv;

  // Step logic of every stage; the first stage compares without shifting.
  always_comb begin
    biou_pkg::biou_step_t s;
    s          = div_step({1'b0, job.inter}, job.uni);
    rem_nxt[0] = s.rem;
    quo_nxt[0] = {{(biou_pkg::IOU_W-1){1'b0}}, s.ge};
    for (int i = 1; i < biou_pkg::DIV_STEPS; i++) begin
      s          = div_step({rem_r[i-1], 1'b0}, uni_r[i-1]);
      rem_nxt[i] = s.rem;
      quo_nxt[i] = {quo_r[i-1][biou_pkg::IOU_W-2:0], s.ge};
    end
  end

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[biou_pkg::DIV_LAST-1:0], job_valid};
    end
  end

  // Stage payloads: partial remainder, quotient so far, divisor and flag.
  always_ff @(posedge clk) begin
    if (adv) begin
      emp_r    <= {emp_r[biou_pkg::DIV_LAST-1:0], job.empty};
      uni_r[0] <= job.uni;
      for (int i = 1; i < biou_pkg::DIV_STEPS; i++) begin
        uni_r[i] <= uni_r[i-1];
      end
      for (int i = 0; i < biou_pkg::DIV_STEPS; i++) begin
        rem_r[i] <= rem_nxt[i];
        quo_r[i] <= quo_nxt[i];
      end
    end
  end

  // The last stage is the output register; an empty union reads as zero.
  assign out_valid       = vld_r[biou_pkg::DIV_LAST];
  assign out_empty_union = emp_r[biou_pkg::DIV_LAST];
  assign out_iou         = emp_r[biou_pkg::DIV_LAST] ? '0 : quo_r[biou_pkg::DIV_LAST];

endmodule

[hdl/box_iou_unit.sv]
`timescale 1ns / 1ps

// Intersection over union of two axis-aligned boxes.
// Input channel (in_valid / in_ready): one request carries two boxes, each as
// a signed Q4.12 center and an unsigned Q4.12 width and height.
// Result channel (out_valid / out_ready): out_iou is the ratio in unsigned
// Q1.15, truncated (32768 means exactly 1.0); out_empty_union is set when both
// boxes have zero area, and out_iou then reads 0.
// Throughput is one request per cycle while the receiver takes results. A
// request passes three geometry stages (overlaps, products, union), the first
// loaded at the accepting edge, one queue slot, and the sixteen stages of the
// divider, one quotient bit each.
// The front end and the divider each advance as a unit; the two-entry queue
// between them lets the front end keep taking requests for a short while after
// the receiver stops taking results. A stalled receiver holds the result
// steady and the backpressure reaches in_ready once the queue fills.
// Reset (rst_n low, synchronous) empties every stage and the queue; in_ready
// is high on the first cycle after reset.
module box_iou_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  biou_pkg::coord_t         in_a_center_x,
  input  biou_pkg::coord_t         in_a_center_y,
  input  biou_pkg::dim_t           in_a_width,
  input  biou_pkg::dim_t           in_a_height,
  input  biou_pkg::coord_t         in_b_center_x,
  input  biou_pkg::coord_t         in_b_center_y,
  input  biou_pkg::dim_t           in_b_width,
  input  biou_pkg::dim_t           in_b_height,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [biou_pkg::IOU_W-1:0] out_iou,
  output logic                     out_empty_union
);

  logic                fe_valid;
  logic                fe_ready;
  biou_pkg::biou_job_t fe_job;
  logic                dq_valid;
  logic                dq_ready;
  biou_pkg::biou_job_t dq_job;

  // Geometry front end.
  biou_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_a_center_x (in_a_center_x),
    .in_a_center_y (in_a_center_y),
    .in_a_width    (in_a_width),
    .in_a_height   (in_a_height),
    .in_b_center_x (in_b_center_x),
    .in_b_center_y (in_b_center_y),
    .in_b_width    (in_b_width),
    .in_b_height   (in_b_height),
    .job_valid     (fe_valid),
    .job_ready     (fe_ready),
    .job           (fe_job)
  );

  // Queue between the front end and the divider.
  biou_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .wr_job   (fe_job),
    .rd_valid (dq_valid),
    .rd_ready (dq_ready),
    .rd_job   (dq_job)
  );

  // Pipelined divider and output register.
  biou_divider u_divider (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (dq_valid),
    .job_ready       (dq_ready),
    .job             (dq_job),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_iou         (out_iou),
    .out_empty_union (out_empty_union)
  );

  // The intersection never exceeds the union, so the ratio is at most one.
  a_iou_at_most_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_empty_union |-> out_iou <= biou_pkg::IOU_W'(32768))
    else $error("iou above one");

  // An empty union always reports a zero ratio.
  a_empty_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_union |-> out_iou == '0)
    else $error("empty union with nonzero iou");

  // A job refused by the full queue stays put in the front end.
  a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fe_valid && !fe_ready |=> fe_valid && $stable(fe_job))
    else $error("front end dropped a stalled job");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !dq_valid)
    else $error("result pending after reset");

endmodule
